// ----- sv/vwap_pkg.sv -----
// ----------------------------------------------------------------------------
// vwap_pkg
// Shared widths, constants and the controller command bundle of the VWAP engine.
// ----------------------------------------------------------------------------
package vwap_pkg;

  localparam int MAX_WINDOW  = 1024;
  localparam int PRICE_BITS  = 24;
  localparam int VOLUME_BITS = 24;
  localparam int PROD_BITS   = PRICE_BITS + VOLUME_BITS;
  localparam int WSUM_BITS   = 64;
  localparam int VSUM_BITS   = 40;
  localparam int CFG_BITS    = 11;
  localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
  localparam int DIV_STEPS   = PRICE_BITS;
  localparam int STEP_BITS   = $clog2(DIV_STEPS);

  // Commands from the controller to the datapath, one strobe per action.
  typedef struct packed {
    logic load;      // capture the accepted bar
    logic mul;       // form price times volume
    logic update;    // update sums, write the ring, advance the slot
    logic div_init;  // seed the divider from the new sums
    logic div_step;  // one restoring divide step
    logic out_load;  // move the result into the output register
  } vwap_cmd_t;

endpackage

// ----- sv/vwap_bar_if.sv -----
// ----------------------------------------------------------------------------
// vwap_bar_if
// Request channel that carries one bar: typical price and volume.
// ----------------------------------------------------------------------------
interface vwap_bar_if
  import vwap_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [PRICE_BITS-1:0]  price;
  logic [VOLUME_BITS-1:0] volume;

  modport source (output valid, price, volume, input ready);
  modport sink   (input valid, price, volume, output ready);
endinterface

// ----- sv/vwap_res_if.sv -----
// ----------------------------------------------------------------------------
// vwap_res_if
// Result channel that carries the average price and its status flags.
// ----------------------------------------------------------------------------
interface vwap_res_if
  import vwap_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [PRICE_BITS-1:0] average_price;
  logic                  no_volume;
  logic                  saturated;

  modport source (output valid, average_price, no_volume, saturated, input ready);
  modport sink   (input valid, average_price, no_volume, saturated, output ready);
endinterface

// ----- sv/vwap_ctrl.sv -----
// ----------------------------------------------------------------------------
// vwap_ctrl
// Sequencer that walks one bar through multiply, update, divide and output.
// ----------------------------------------------------------------------------
module vwap_ctrl
  import vwap_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output vwap_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_UPD,
    S_DINIT,
    S_DIV,
    S_DONE
  } state_e;

  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(DIV_STEPS - 1);

  state_e               state_q;
  logic [STEP_BITS-1:0] cnt_q;
  logic                 out_valid_q;
  logic                 out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mul      = (state_q == S_MUL);
    cmd_o.update   = (state_q == S_UPD);
    cmd_o.div_init = (state_q == S_DINIT);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.out_load = (state_q == S_DONE) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_MUL;
          end
        end
        S_MUL:   state_q <= S_UPD;
        S_UPD:   state_q <= S_DINIT;
        S_DINIT: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LAST_STEP) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/vwap_dp.sv -----
// ----------------------------------------------------------------------------
// vwap_dp
// Datapath: multiplier, window rings, running sums, serial divider, output.
// ----------------------------------------------------------------------------
module vwap_dp
  import vwap_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_BITS-1:0]    cfg_wdata_i,
  input  vwap_cmd_t              cmd_i,
  input  logic [PRICE_BITS-1:0]  price_i,
  input  logic [VOLUME_BITS-1:0] volume_i,
  output logic [PRICE_BITS-1:0]  average_price_o,
  output logic                   no_volume_o,
  output logic                   saturated_o
);

  localparam logic [CFG_BITS-1:0]   MAX_WIN   = CFG_BITS'(MAX_WINDOW);
  localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;

  // Ring memories, written in the update cycle, read continuously at the slot.
  logic [PROD_BITS-1:0]   prod_ring [MAX_WINDOW];
  logic [VOLUME_BITS-1:0] vol_ring  [MAX_WINDOW];

  logic [CFG_BITS-1:0]    window_q;
  logic [WSUM_BITS-1:0]   ws_q;
  logic [VSUM_BITS-1:0]   vs_q;
  logic [SLOT_BITS-1:0]   slot_q;
  logic [CFG_BITS-1:0]    held_q;

  logic [PRICE_BITS-1:0]  price_q;
  logic [VOLUME_BITS-1:0] vol_q;
  logic [PROD_BITS-1:0]   prod_q;
  logic [PROD_BITS-1:0]   prod_rd_q;
  logic [VOLUME_BITS-1:0] vol_rd_q;
  logic [VSUM_BITS-1:0]   rem_q;
  logic [PRICE_BITS-1:0]  dvd_q;
  logic                   big_q;
  logic                   novol_q;
  logic                   sat_q;
  logic [PRICE_BITS-1:0]  avg_q;
  logic                   novol_out_q;
  logic                   sat_out_q;

  logic [CFG_BITS-1:0]    win_n;
  logic                   full;
  logic [WSUM_BITS:0]     ws_cum;
  logic [VSUM_BITS:0]     vs_cum;
  logic [WSUM_BITS-1:0]   ws_win;
  logic [VSUM_BITS-1:0]   vs_win;
  logic [WSUM_BITS-1:0]   ws_d;
  logic [VSUM_BITS-1:0]   vs_d;
  logic [CFG_BITS-1:0]    slot_inc;
  logic [VSUM_BITS:0]     trial;
  logic                   cum_sat;

  assign win_n    = (window_q > MAX_WIN) ? MAX_WIN : window_q;
  assign full     = (held_q >= win_n);
  assign slot_inc = {1'b0, slot_q} + 1'b1;

  always_comb begin
    ws_cum = {1'b0, ws_q} + {{(WSUM_BITS + 1 - PROD_BITS){1'b0}}, prod_q};
    vs_cum = {1'b0, vs_q} + {{(VSUM_BITS + 1 - VOLUME_BITS){1'b0}}, vol_q};
    ws_win = ws_q + {{(WSUM_BITS - PROD_BITS){1'b0}}, prod_q}
             - (full ? {{(WSUM_BITS - PROD_BITS){1'b0}}, prod_rd_q} : '0);
    vs_win = vs_q + {{(VSUM_BITS - VOLUME_BITS){1'b0}}, vol_q}
             - (full ? {{(VSUM_BITS - VOLUME_BITS){1'b0}}, vol_rd_q} : '0);
    if (window_q == '0) begin
      ws_d = ws_cum[WSUM_BITS] ? '1 : ws_cum[WSUM_BITS-1:0];
      vs_d = vs_cum[VSUM_BITS] ? '1 : vs_cum[VSUM_BITS-1:0];
    end else begin
      ws_d = ws_win;
      vs_d = vs_win;
    end
  end

  assign trial   = {rem_q, dvd_q[PRICE_BITS-1]} - {1'b0, vs_q};
  assign cum_sat = (window_q == '0) && ((ws_q == '1) || (vs_q == '1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      ws_q     <= '0;
      vs_q     <= '0;
      slot_q   <= '0;
      held_q   <= '0;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
      ws_q     <= '0;
      vs_q     <= '0;
      slot_q   <= '0;
      held_q   <= '0;
    end else if (cmd_i.update) begin
      ws_q <= ws_d;
      vs_q <= vs_d;
      if (window_q != '0) begin
        slot_q <= (slot_inc >= win_n) ? '0 : slot_inc[SLOT_BITS-1:0];
        if (!full) begin
          held_q <= held_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_rd_q <= prod_ring[slot_q];
    vol_rd_q  <= vol_ring[slot_q];
    if (cmd_i.update && (window_q != '0)) begin
      prod_ring[slot_q] <= prod_q;
      vol_ring[slot_q]  <= vol_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      price_q <= price_i;
      vol_q   <= volume_i;
    end
    if (cmd_i.mul) begin
      prod_q <= price_q * vol_q;
    end
    if (cmd_i.div_init) begin
      // A high part at or above the divisor means the quotient overflows.
      rem_q   <= ws_q[WSUM_BITS-1:PRICE_BITS];
      dvd_q   <= ws_q[PRICE_BITS-1:0];
      big_q   <= (ws_q[WSUM_BITS-1:PRICE_BITS] >= vs_q);
      novol_q <= (vs_q == '0);
      sat_q   <= cum_sat;
    end
    if (cmd_i.div_step) begin
      if (!trial[VSUM_BITS]) begin
        rem_q <= trial[VSUM_BITS-1:0];
        dvd_q <= {dvd_q[PRICE_BITS-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[VSUM_BITS-2:0], dvd_q[PRICE_BITS-1]};
        dvd_q <= {dvd_q[PRICE_BITS-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      avg_q       <= novol_q ? '0 : (big_q ? PRICE_MAX : dvd_q);
      novol_out_q <= novol_q;
      sat_out_q   <= sat_q;
    end
  end

  assign average_price_o = avg_q;
  assign no_volume_o     = novol_out_q;
  assign saturated_o     = sat_out_q;

endmodule

// ----- sv/windowed_vwap_engine_top.sv -----
// A result becomes valid once its bar has gone through the multiply, update,
// divide-init and restoring divide states and the output register is free.
// A new bar is taken only after the previous one has reached the output register.
// A finished result waits in the output register while the next bar runs.
// Reset (rst_ni low, asynchronous) clears sums, slot, fill count and window;
// the rings need no clearing, since only written entries are ever read.
// ----------------------------------------------------------------------------
// windowed_vwap_engine_top
// Volume weighted average price over all bars or over a sliding window.
// ----------------------------------------------------------------------------
module windowed_vwap_engine_top
  import vwap_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_BITS-1:0] cfg_wdata_i,
  vwap_bar_if.sink            bar_i,
  vwap_res_if.source          res_o
);

  // The controller sequences each request through its phases: capture,
  // multiply, sum update with ring access, divider seeding, a 24-step divide,
  // and hand-off to the output register. The datapath only acts on its command strobes.
  vwap_cmd_t cmd;

  vwap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bar_i.valid),
    .in_ready_o  (bar_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd)
  );

  // The quotient is limited to the price width, so the divider only needs
  // one step per result bit once the upper part has been checked against
  // the volume sum; larger quotients saturate to the top price.
  vwap_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .price_i         (bar_i.price),
    .volume_i        (bar_i.volume),
    .average_price_o (res_o.average_price),
    .no_volume_o     (res_o.no_volume),
    .saturated_o     (res_o.saturated)
  );

endmodule

// ----- sv/vwap_checker.sv -----
// ----------------------------------------------------------------------------
// vwap_checker
// Port-level assertions for the VWAP engine, bound to the top level.
// ----------------------------------------------------------------------------
module vwap_checker
  import vwap_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [PRICE_BITS-1:0] average_price_i,
  input logic                  no_volume_i,
  input logic                  saturated_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // The engine works on one request at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while busy");

  // An empty volume sum forces a zero price.
  a_novol_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && no_volume_i |-> average_price_i == '0)
    else $error("nonzero price with no volume");

  // A saturated sum implies traded volume.
  a_sat_vol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |-> !no_volume_i)
    else $error("saturation flagged with no volume");

endmodule

bind windowed_vwap_engine_top vwap_checker u_vwap_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (bar_i.valid),
  .in_ready_i      (bar_i.ready),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .average_price_i (res_o.average_price),
  .no_volume_i     (res_o.no_volume),
  .saturated_i     (res_o.saturated)
);

// ----- tb/sv/windowed_vwap_engine_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_vwap_engine_top_test
// Self-checking bench that feeds bars, rewrites the window between phases and
// compares every average price and flag with a cycle-free model of the engine.
// ----------------------------------------------------------------------------
module windowed_vwap_engine_top_test;
  import vwap_pkg::*;

  // Cycles without any handshake before the run is declared hung. The limit is
  // generous against a bar's processing and the longest idle stretch of either side.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Cycles allowed after the last result so that a stray result shows up.
  localparam int unsigned TAIL_CYCLES    = 40;

  // What the stimulus queue can hold: a bar request, a pause until the engine
  // has answered every bar, or a window write (which also waits for that).
  typedef enum logic [1:0] {
    REQ_BAR,
    REQ_DRAIN,
    REQ_WINDOW
  } req_kind_e;

  typedef struct {
    req_kind_e              kind;
    logic [CFG_BITS-1:0]    window;
    logic [PRICE_BITS-1:0]  price;
    logic [VOLUME_BITS-1:0] volume;
  } bar_plan_t;

  typedef struct packed {
    logic [PRICE_BITS-1:0] average_price;
    logic                  no_volume;
    logic                  saturated;
  } vwap_answer_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;

  vwap_bar_if bar_ch ();
  vwap_res_if res_ch ();

  windowed_vwap_engine_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .bar_i       (bar_ch),
    .res_o       (res_ch)
  );

  // Stimulus still to be sent and the answers the engine still owes.
  bar_plan_t    bar_plan_q[$];
  vwap_answer_t vwap_due_q[$];

  // The driver and the monitor each own one of these counters and update it
  // with a nonblocking assignment, so either side may read the other's count
  // at a clock edge without caring about process order.
  int unsigned bars_taken   = 0;
  int unsigned results_done = 0;
  logic        stim_done    = 1'b0;
  int unsigned fail_count   = 0;
  int unsigned idle_cycles  = 0;

  // Driver and monitor idling state.
  int unsigned send_gap  = 0;
  int unsigned send_calm = 0;
  int unsigned recv_stall = 0;
  int unsigned recv_calm  = 0;

  // Model state: the window register, both running sums and the two rings
  // that remember what each bar in the window contributed.
  logic [CFG_BITS-1:0]    win_len;
  logic [WSUM_BITS-1:0]   wsum;
  logic [VSUM_BITS-1:0]   vsum;
  logic [PROD_BITS-1:0]   prod_ring [MAX_WINDOW];
  logic [VOLUME_BITS-1:0] vol_ring  [MAX_WINDOW];
  int unsigned            ring_slot;
  int unsigned            ring_fill;

  // --------------------------------------------------------------------------
  // Clock and reset.
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Every input of the engine is known from time zero on.
  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    bar_ch.valid  = 1'b0;
    bar_ch.price  = '0;
    bar_ch.volume = '0;
    res_ch.ready  = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Model of the engine.
  // --------------------------------------------------------------------------

  // Any write of the window register starts both sums from scratch.
  function automatic void restart_sums();
    wsum      = '0;
    vsum      = '0;
    ring_slot = 0;
    ring_fill = 0;
  endfunction

  // Folds one bar into the sums and returns the answer the engine must give.
  function automatic vwap_answer_t next_vwap(logic [PRICE_BITS-1:0] price,
                                             logic [VOLUME_BITS-1:0] volume);
    logic [PROD_BITS-1:0]   prod;
    logic [WSUM_BITS:0]     wide_w;
    logic [VSUM_BITS:0]     wide_v;
    logic [WSUM_BITS-1:0]   quot;
    int unsigned            span;
    int unsigned            slot;
    vwap_answer_t           ans;
    prod = PROD_BITS'(price) * PROD_BITS'(volume);
    ans  = '0;
    if (win_len == 0) begin
      // Cumulative mode: each sum sticks at all ones once it would carry out.
      wide_w = {1'b0, wsum} + (WSUM_BITS + 1)'(prod);
      wsum   = wide_w[WSUM_BITS] ? '1 : wide_w[WSUM_BITS-1:0];
      wide_v = {1'b0, vsum} + (VSUM_BITS + 1)'(volume);
      vsum   = wide_v[VSUM_BITS] ? '1 : wide_v[VSUM_BITS-1:0];
      ans.saturated = (&wsum) | (&vsum);
    end else begin
      // Sliding window: once the window is full, the bar that falls out of
      // it is taken off before the new one goes in. Oversized windows act as
      // the largest ring the engine has.
      span = (win_len > MAX_WINDOW) ? MAX_WINDOW : int'(win_len);
      slot = ring_slot % span;
      if (ring_fill >= span) begin
        wsum = wsum - WSUM_BITS'(prod_ring[slot]);
        vsum = vsum - VSUM_BITS'(vol_ring[slot]);
      end else begin
        ring_fill++;
      end
      prod_ring[slot] = prod;
      vol_ring[slot]  = volume;
      wsum      = wsum + WSUM_BITS'(prod);
      vsum      = vsum + VSUM_BITS'(volume);
      ring_slot = (slot + 1 >= span) ? 0 : slot + 1;
    end
    if (vsum == 0) begin
      ans.no_volume = 1'b1;
    end else begin
      quot = wsum / WSUM_BITS'(vsum);
      ans.average_price = (quot > WSUM_BITS'({PRICE_BITS{1'b1}})) ? '1 :
                          quot[PRICE_BITS-1:0];
    end
    return ans;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Idle length for either side: mostly none or short, now and then long,
  // and from time to time a calm stretch with no idling at all.
  function automatic int unsigned draw_gap(inout int unsigned calm);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (roll < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents bar requests from the plan queue. Window writes and
  // pauses only go ahead once every bar taken so far has been answered, which
  // keeps register writes to moments when the engine is idle.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic offer;
    logic write_now;
    logic took;
    if (!rst_ni) begin
      bar_ch.valid <= 1'b0;
      cfg_we       <= 1'b0;
    end else begin
      took      = bar_ch.valid && bar_ch.ready;
      offer     = bar_ch.valid && !took;
      write_now = 1'b0;
      if (took) begin
        bars_taken <= bars_taken + 1;
        send_gap    = draw_gap(send_calm);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (bar_plan_q.size() > 0) begin
          case (bar_plan_q[0].kind)
            REQ_BAR: begin
              offer          = 1'b1;
              bar_ch.price  <= bar_plan_q[0].price;
              bar_ch.volume <= bar_plan_q[0].volume;
              void'(bar_plan_q.pop_front());
            end
            default: begin
              // The counts are last edge's values, so a bar taken right now
              // is excluded explicitly.
              if (!took && bars_taken == results_done) begin
                if (bar_plan_q[0].kind == REQ_WINDOW) begin
                  write_now  = 1'b1;
                  cfg_wdata <= bar_plan_q[0].window;
                end
                void'(bar_plan_q.pop_front());
                if (bar_plan_q.size() == 0) begin
                  stim_done <= 1'b1;
                end
              end
            end
          endcase
        end
      end
      bar_ch.valid <= offer;
      cfg_we       <= write_now;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each result against the oldest answer due, follows
  // window writes, predicts every accepted bar and throttles the result side.
  // The check comes before the prediction, since a result leaving at the
  // same edge as a new bar always belongs to an older one.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    vwap_answer_t want;
    logic         take_next;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      win_len       = '0;
      restart_sums();
    end else begin
      take_next = res_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        results_done <= results_done + 1;
        if (vwap_due_q.size() == 0) begin
          $error("result 0x%0h arrived with no bar outstanding",
                 res_ch.average_price);
          fail_count++;
        end else begin
          want = vwap_due_q.pop_front();
          check_field("average_price", want.average_price, res_ch.average_price);
          check_field("no_volume", want.no_volume, res_ch.no_volume);
          check_field("saturated", want.saturated, res_ch.saturated);
        end
        recv_stall = draw_gap(recv_calm);
        take_next  = (recv_stall == 0);
      end else if (!res_ch.ready) begin
        if (recv_stall > 0) recv_stall--;
        take_next = (recv_stall == 0);
      end else if ($urandom_range(0, 7) == 0) begin
        // Drop ready while waiting, so stalls also land mid-computation.
        recv_stall = draw_gap(recv_calm);
        take_next  = (recv_stall == 0);
      end
      if (cfg_we) begin
        win_len = cfg_wdata;
        restart_sums();
      end
      if (bar_ch.valid && bar_ch.ready) begin
        vwap_due_q.push_back(next_vwap(bar_ch.price, bar_ch.volume));
      end
      res_ch.ready <= take_next;
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a long run of cycles with no handshake means the engine hung.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((bar_ch.valid && bar_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus plan.
  // --------------------------------------------------------------------------
  function automatic void add_req(req_kind_e kind, logic [CFG_BITS-1:0] window,
                                  logic [PRICE_BITS-1:0] price,
                                  logic [VOLUME_BITS-1:0] volume);
    bar_plan_t req;
    req.kind   = kind;
    req.window = window;
    req.price  = price;
    req.volume = volume;
    bar_plan_q.push_back(req);
  endfunction

  // Prices cluster in a plausible band, with the extremes and raw noise mixed in.
  function automatic logic [PRICE_BITS-1:0] pick_price();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 16) return '1;
    if (roll < 60) return PRICE_BITS'($urandom_range(24'h000800, 24'h040000));
    return PRICE_BITS'($urandom);
  endfunction

  function automatic logic [VOLUME_BITS-1:0] pick_volume();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 18) return '1;
    if (roll < 58) return VOLUME_BITS'($urandom_range(1, 2000));
    return VOLUME_BITS'($urandom);
  endfunction

  // One phase: a window write and then random bars. Small windows sometimes
  // get a run of zero-volume bars that fills the whole window, so the volume
  // sum drains back to zero.
  function automatic void queue_phase(logic [CFG_BITS-1:0] window,
                                      int unsigned bars);
    int unsigned queued;
    int unsigned run;
    queued = 0;
    add_req(REQ_WINDOW, window, '0, '0);
    while (queued < bars) begin
      if (window != 0 && window <= 16 && $urandom_range(0, 19) == 0) begin
        for (run = 0; run < window; run++) begin
          add_req(REQ_BAR, '0, pick_price(), '0);
        end
        queued += 32'(window);
      end else begin
        add_req(REQ_BAR, '0, pick_price(), pick_volume());
        queued++;
      end
      if ($urandom_range(0, 149) == 0) add_req(REQ_DRAIN, '0, '0, '0);
    end
  endfunction

  initial begin
    int unsigned idx;

    // Cumulative mode straight out of reset. The first bars carry no volume,
    // so the average is forced to zero and flagged.
    add_req(REQ_BAR, '0, 24'h123456, '0);
    add_req(REQ_BAR, '0, '1, '0);
    add_req(REQ_BAR, '0, '0, '1);
    add_req(REQ_BAR, '0, '1, '1);
    add_req(REQ_BAR, '0, '1, 24'd1);
    add_req(REQ_BAR, '0, 24'd1, 24'd1);
    add_req(REQ_BAR, '0, 24'h000100, 24'd500);
    add_req(REQ_BAR, '0, 24'hAAAAAA, 24'h555555);
    add_req(REQ_BAR, '0, 24'h555555, 24'hAAAAAA);
    // Hold back until the engine has caught up, then go on.
    add_req(REQ_DRAIN, '0, '0, '0);
    add_req(REQ_BAR, '0, 24'h7FFFFF, 24'h800000);

    // Shortest window: every answer is just the newest bar's price, and a
    // zero-volume bar empties the window at once.
    add_req(REQ_WINDOW, 11'd1, '0, '0);
    add_req(REQ_BAR, '0, 24'h00C880, 24'd5);
    add_req(REQ_BAR, '0, '1, '0);
    add_req(REQ_BAR, '0, '1, '1);
    add_req(REQ_BAR, '0, '0, '1);

    // Two-bar window: a bar leaves the window on the third request.
    add_req(REQ_WINDOW, 11'd2, '0, '0);
    add_req(REQ_BAR, '0, 24'h010000, 24'd100);
    add_req(REQ_BAR, '0, 24'h020000, 24'd300);
    add_req(REQ_BAR, '0, 24'h030000, '0);
    add_req(REQ_BAR, '0, 24'h040000, '0);

    // Window above the ring size acts as the ring size.
    add_req(REQ_WINDOW, {CFG_BITS{1'b1}}, '0, '0);
    add_req(REQ_BAR, '0, '1, '1);
    add_req(REQ_BAR, '0, 24'h000001, '1);

    // Random phases: rewriting zero clears the cumulative sums, then a spread
    // of windows. The long phase at the largest setting wraps the full ring.
    queue_phase(11'd0, 40);
    queue_phase(11'd1, 30);
    queue_phase(11'd2, 30);
    for (idx = 0; idx < 3; idx++) begin
      queue_phase(CFG_BITS'($urandom_range(3, 40)), 40);
    end
    queue_phase(11'(MAX_WINDOW), 30);
    queue_phase({CFG_BITS{1'b1}}, 1080);
    queue_phase(11'd0, 40);
    add_req(REQ_DRAIN, '0, '0, '0);

    // The driver flags the end once the final pause has seen every answer.
    wait (stim_done);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && vwap_due_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/vwap_pkg.sv
sv/vwap_bar_if.sv
sv/vwap_res_if.sv
sv/vwap_ctrl.sv
sv/vwap_dp.sv
sv/windowed_vwap_engine_top.sv
sv/vwap_checker.sv
tb/sv/windowed_vwap_engine_top_test.sv
